FILE: rtl/core/pbm_pkg.sv
// Package for the pixel blend block: blend mode codes and lane control struct.
// Used by pbm_lane, pbm_merge and pixel_blend_modes.
package pbm_pkg;

    localparam int MODE_BITS = 4;

    localparam logic [MODE_BITS-1:0] MODE_NORMAL     = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD        = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_SUBTRACT   = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_MULTIPLY   = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_DIVIDE     = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_SCREEN     = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_OVERLAY    = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_DODGE      = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_BURN       = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_DIFFERENCE = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_DARKEN     = 4'd10;
    localparam logic [MODE_BITS-1:0] MODE_LIGHTEN    = 4'd11;

    // Pipeline control that travels beside the lane data.
    typedef struct packed {
        logic                 valid;
        logic [MODE_BITS-1:0] mode;
        logic                 force_zero;
        logic                 force_max;
    } pbm_ctrl_t;

endpackage

FILE: rtl/core/pbm_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at M.
// Depends on nothing; used by pbm_lane.
module pbm_div #(
    parameter int W = 8
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [2*W-1:0] num,
    input  logic [W-1:0]   den,
    output logic [W-1:0]   quot
);
    // Quotient is clamped to W+1 bits: any value >= 2^W saturates anyway.
    localparam int QB = W + 1;
    localparam logic [W-1:0] M = {W{1'b1}};

    // Stage k holds the partial result after quotient bit QB-1-k.
    logic [2*W-1:0] rem_reg  [QB];
    logic [QB-1:0]  q_reg    [QB];
    logic [W-1:0]   den_reg  [QB];
    logic           big_reg  [QB];
    logic           zero_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [2*W-1:0] rem_in;
        logic [QB-1:0]  q_in;
        logic [W-1:0]   den_in;
        logic           big_in;
        logic           zero_in;
        logic [3*W:0]   trial;
        logic [3*W:0]   rem_x;
        if (k == 0) begin : g_first
            assign rem_in  = num;
            assign q_in    = '0;
            assign den_in  = den;
            // Overflow beyond W+1 quotient bits: num >= den * 2^QB.
            assign big_in  = (num >> QB) >= {{W{1'b0}}, den};
            assign zero_in = (den == '0);
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign big_in  = big_reg[k-1];
            assign zero_in = zero_reg[k-1];
        end
        assign rem_x = {{(W+1){1'b0}}, rem_in};
        assign trial = {{(2*W+1){1'b0}}, den_in} << SH;
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k]  <= den_in;
                big_reg[k]  <= big_in;
                zero_reg[k] <= zero_in;
                if (rem_x >= trial) begin
                    rem_reg[k] <= (2*W)'(rem_x - trial);
                    q_reg[k]   <= q_in | (QB'(1) << SH);
                end else begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
            end
        end
    end

    always_comb begin
        if (zero_reg[QB-1] || big_reg[QB-1] || q_reg[QB-1][W]) begin
            quot = M;
        end else begin
            quot = q_reg[QB-1][W-1:0];
        end
    end
endmodule

FILE: rtl/core/pbm_lane.sv
// One channel lane of the blend: all modes for one bottom/top channel pair.
// Depends on pbm_pkg and pbm_div.
module pbm_lane #(
    parameter int W = 8
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [pbm_pkg::MODE_BITS-1:0] mode,
    input  logic [W-1:0]               b,
    input  logic [W-1:0]               t,
    output logic [W-1:0]               res
);
    localparam logic [W-1:0] M = {W{1'b1}};
    localparam int LAT = W + 2;   // divider depth plus entry stage
    localparam logic [2*W-1:0] MW    = {{W{1'b0}}, M};
    localparam logic [2*W-1:0] ONE_W = {{(2*W-1){1'b0}}, 1'b1};
    localparam logic [2*W+1:0] MX    = {{(W+2){1'b0}}, M};
    localparam logic [2*W+1:0] ONE_X = {{(2*W+1){1'b0}}, 1'b1};

    // Stage 0: operand setup and multiplies.
    logic [W-1:0]   nb, nt;
    logic [2*W-1:0] bw, tw, nbw, ntw;
    logic [2*W-1:0] prod_next;
    logic [2*W-1:0] dnum;
    logic [W-1:0]   dden;
    logic           hi_b;
    assign nb   = M - b;
    assign nt   = M - t;
    assign bw   = {{W{1'b0}}, b};
    assign tw   = {{W{1'b0}}, t};
    assign nbw  = {{W{1'b0}}, nb};
    assign ntw  = {{W{1'b0}}, nt};
    assign hi_b = ({1'b0, b} << 1) >= {1'b0, M};

    always_comb begin
        case (mode)
            pbm_pkg::MODE_SCREEN:  prod_next = nbw * ntw;
            pbm_pkg::MODE_OVERLAY: prod_next = hi_b ? nbw * ntw : bw * tw;
            pbm_pkg::MODE_BURN:    prod_next = nbw * MW;
            default:               prod_next = bw * tw;
        endcase
        dnum = bw * MW;
        dden = (mode == pbm_pkg::MODE_DODGE) ? nt : t;
    end

    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   b_reg, t_reg;
    logic [pbm_pkg::MODE_BITS-1:0] mode_reg;
    logic           hi_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            b_reg    <= b;
            t_reg    <= t;
            mode_reg <= mode;
            hi_reg   <= hi_b;
        end
    end

    // Stage 1: divide product by M (exact: x/M for x < M*M+M).
    // floor(x/M) = (x + (x>>W) + 1) >> W for x < M*M+M.
    logic [2*W+1:0] p2;
    logic [2*W+1:0] pm;
    logic [2*W+1:0] fl;
    logic [2*W+1:0] cl;
    logic [W-1:0]   flq, clq;
    logic [W-1:0]   simple_next;
    assign p2  = (mode_reg == pbm_pkg::MODE_OVERLAY) ? {1'b0, prod_reg, 1'b0}
                                                     : {2'b0, prod_reg};
    assign pm  = p2 + MX - ONE_X;
    assign fl  = (p2 + (p2 >> W) + ONE_X) >> W;
    assign cl  = (pm + (pm >> W) + ONE_X) >> W;
    assign flq = (fl > MX) ? M : fl[W-1:0];
    assign clq = (cl > MX) ? M : cl[W-1:0];

    always_comb begin
        logic [W:0] sum;
        sum = {1'b0, b_reg} + {1'b0, t_reg};
        case (mode_reg)
            pbm_pkg::MODE_ADD:        simple_next = sum[W] ? M : sum[W-1:0];
            pbm_pkg::MODE_SUBTRACT:   simple_next = (b_reg > t_reg) ? b_reg - t_reg : '0;
            pbm_pkg::MODE_MULTIPLY:   simple_next = flq;
            pbm_pkg::MODE_SCREEN:     simple_next = M - clq;
            pbm_pkg::MODE_OVERLAY:    simple_next = hi_reg ? M - clq : flq;
            pbm_pkg::MODE_DIFFERENCE: simple_next = (b_reg > t_reg) ? b_reg - t_reg
                                                                    : t_reg - b_reg;
            pbm_pkg::MODE_DARKEN:     simple_next = (b_reg < t_reg) ? b_reg : t_reg;
            pbm_pkg::MODE_LIGHTEN:    simple_next = (b_reg > t_reg) ? b_reg : t_reg;
            default:                  simple_next = t_reg;
        endcase
    end

    // Burn: M - ceil((M-b)*M/t), 0 when t == 0 or (M-b) >= t.
    // ceil(a/t) = floor((a + t - 1)/t); quotient < M here so no clamp matters.
    logic [2*W-1:0] bnum;
    logic [2*W-1:0] div_num;
    logic [W-1:0]   div_den;
    logic           burn0_next;
    assign burn0_next = (t == '0) || (nb >= t);
    assign bnum    = nbw * MW + tw - ONE_W;
    assign div_num = (mode == pbm_pkg::MODE_BURN) ? bnum : dnum;
    assign div_den = dden;

    logic [W-1:0] quot;
    pbm_div #(.W(W)) u_div (
        .aclk (aclk),
        .en   (en),
        .num  (div_num),
        .den  (div_den),
        .quot (quot)
    );

    // Delay the simple result and flags to line up with the divider output.
    logic [W-1:0] simple_pipe [LAT-2];
    logic [pbm_pkg::MODE_BITS-1:0] mode_pipe [LAT-2];
    logic burn0_pipe [LAT-1];
    always_ff @(posedge aclk) begin
        if (en) begin
            simple_pipe[0] <= simple_next;
            mode_pipe[0]   <= mode_reg;
            burn0_pipe[0]  <= burn0_next;
            for (int i = 1; i < LAT-2; i++) begin
                simple_pipe[i] <= simple_pipe[i-1];
                mode_pipe[i]   <= mode_pipe[i-1];
            end
            for (int i = 1; i < LAT-1; i++) begin
                burn0_pipe[i] <= burn0_pipe[i-1];
            end
        end
    end

    always_comb begin
        case (mode_pipe[LAT-3])
            pbm_pkg::MODE_DIVIDE, pbm_pkg::MODE_DODGE: res = quot;
            pbm_pkg::MODE_BURN: res = burn0_pipe[LAT-2] ? '0 : M - quot;
            default: res = simple_pipe[LAT-3];
        endcase
    end
endmodule

FILE: rtl/core/pbm_merge.sv
// Merge stage: applies whole-pixel overrides to the lane results.
// Depends on pbm_pkg.
module pbm_merge #(
    parameter int W = 8
) (
    input  pbm_pkg::pbm_ctrl_t ctrl,
    input  logic [4*W-1:0]     lanes,
    output logic [4*W-1:0]     pixel
);
    always_comb begin
        if (ctrl.force_zero) begin
            pixel = '0;
        end else if (ctrl.force_max) begin
            pixel = '1;
        end else begin
            pixel = lanes;
        end
    end
endmodule

FILE: rtl/core/pixel_blend_modes.sv
// Pixel blend modes: four channel lanes blend bottom and top RGBA pixels.
// Pipeline: CHANNEL_BITS+2 register stages, the bit-per-stage pipelined divider
// in each lane plus the output register.
// Throughput: one pixel per clock while m_tready is high; a held output beat
// stalls the whole pipe and drops s_tready.
// Reset: synchronous active-low aresetn clears valid bits and the mode to normal.
// Depends on pbm_pkg, pbm_lane, pbm_div, pbm_merge.
module pixel_blend_modes #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // cfg: mode select in bits [3:0]
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                cfg_data,
    // tdata: bottom_red, bottom_green, bottom_blue, bottom_alpha,
    //        top_red, top_green, top_blue, top_alpha (lowest first)
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [8*CHANNEL_BITS-1:0] s_tdata,
    // tdata: out_red, out_green, out_blue, out_alpha (lowest first)
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [4*CHANNEL_BITS-1:0] m_tdata
);
    localparam int W   = CHANNEL_BITS;
    localparam int LAT = W + 2;
    localparam logic [W-1:0] M = {W{1'b1}};

    logic [pbm_pkg::MODE_BITS-1:0] mode_reg;
    assign cfg_ready = 1'b1;

    // Whole pipeline stalls together when the output holds a beat.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pbm_pkg::MODE_NORMAL;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data[pbm_pkg::MODE_BITS-1:0];
        end
    end

    logic [W-1:0] b [4];
    logic [W-1:0] t [4];
    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign b[i] = s_tdata[i*W +: W];
        assign t[i] = s_tdata[(i+4)*W +: W];
    end

    // Whole-pixel override flags from the RGB divisor.
    pbm_pkg::pbm_ctrl_t ctrl_in;
    logic t_rgb_zero, t_rgb_max;
    assign t_rgb_zero = (t[0] == '0) && (t[1] == '0) && (t[2] == '0);
    assign t_rgb_max  = (t[0] == M) && (t[1] == M) && (t[2] == M);
    always_comb begin
        ctrl_in.valid      = s_tvalid;
        ctrl_in.mode       = mode_reg;
        ctrl_in.force_zero = ((mode_reg == pbm_pkg::MODE_DIVIDE) && t_rgb_zero)
                          || ((mode_reg == pbm_pkg::MODE_DODGE) && t_rgb_max);
        ctrl_in.force_max  = (mode_reg == pbm_pkg::MODE_BURN) && t_rgb_zero;
    end

    // Control delay line, advanced with the lanes.
    pbm_pkg::pbm_ctrl_t ctrl_pipe [LAT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                ctrl_pipe[i].valid <= 1'b0;
            end
        end else if (en) begin
            ctrl_pipe[0] <= ctrl_in;
            for (int i = 1; i < LAT; i++) begin
                ctrl_pipe[i] <= ctrl_pipe[i-1];
            end
        end
    end

    logic [4*W-1:0] lanes;
    for (genvar i = 0; i < 4; i++) begin : g_lane
        pbm_lane #(.W(W)) u_lane (
            .aclk (aclk),
            .en   (en),
            .mode (mode_reg),
            .b    (b[i]),
            .t    (t[i]),
            .res  (lanes[i*W +: W])
        );
    end

    logic [4*W-1:0] pixel;
    pbm_merge #(.W(W)) u_merge (
        .ctrl  (ctrl_pipe[LAT-2]),
        .lanes (lanes),
        .pixel (pixel)
    );

    // Output register: the last pipeline stage.
    logic [4*W-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= pixel;
        end
    end
    assign m_tvalid = ctrl_pipe[LAT-1].valid;
    assign m_tdata  = out_reg;
endmodule
